[sv/tsp_pkg.sv]
// Shared types, character codes and digit helpers for the time string parser.
// No dependencies; imported by tsp_step and time_string_parser.
package tsp_pkg;

    localparam int unsigned HourMax   = 23;
    localparam int unsigned MinSecMax = 59;
    localparam int unsigned MaxLen    = 8;

    localparam logic [7:0] NUL_CODE   = 8'h00;
    localparam logic [7:0] COLON_CODE = 8'h3A;
    localparam logic [7:0] ZERO_CODE  = 8'h30;
    localparam logic [7:0] NINE_CODE  = 8'h39;

    typedef enum logic [3:0] {
        PH_H1,
        PH_H2_OR_COLON,
        PH_COLON,
        PH_M1,
        PH_M2,
        PH_END_OR_COLON,
        PH_S1,
        PH_S2,
        PH_END
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  char_count;
        logic [6:0]  hour_acc;
        logic [6:0]  minute_acc;
        logic [6:0]  second_acc;
        logic        failed;
        logic        ended;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        logic [4:0]  hours;
        logic [5:0]  minutes;
    } parse_result_t;

    localparam parse_state_t CLEAR_STATE = '{
        phase:      PH_H1,
        char_count: 4'd0,
        hour_acc:   7'd0,
        minute_acc: 7'd0,
        second_acc: 7'd0,
        failed:     1'b0,
        ended:      1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ZERO_CODE) && (c <= NINE_CODE);
    endfunction

    // acc * 10 + digit, kept to 7 bits
    function automatic logic [6:0] add_digit(input logic [6:0] acc, input logic [7:0] c);
        logic [10:0] sum;
        logic [7:0]  d;
        d   = c - ZERO_CODE;
        sum = ({4'd0, acc} * 11'd10) + {3'd0, d};
        return sum[6:0];
    endfunction

endpackage

[sv/time_string_parser.sv]
// Top level of the time string parser: input register, parse state, stored time, result register.
// Depends on tsp_pkg and tsp_step.
//
//  channel  | signals                               | direction | role
//  ---------+---------------------------------------+-----------+------------------------------
//  in       | in_valid, in_ready, char_code,        | to block  | one payload byte per item,
//           | last_char                             |           | last_char marks the final one
//  out      | out_valid, out_ready, valid_res,      | from      | one result per payload, given
//           | hour_value, minute_value, changed     | block     | for the final byte
//
// One item per cycle sustained while no held result stalls a final byte. An item is held in the
// input register while the parse step updates the state; the result of a final byte enters the
// result register as that byte leaves the input register, so out_valid rises once the final byte
// has passed the input register and then the result register.
// A held result stalls only final bytes; other bytes keep flowing into the parse state.
// Reset clears the parse state, the stored time and both valid flags.
module time_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [4:0]  hour_value,
    output logic [5:0]  minute_value,
    output logic        changed
);
    import tsp_pkg::*;

    // input register
    logic          in_valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;

    // parse state and stored time
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    logic [4:0]    stored_hours_reg;
    logic [5:0]    stored_minutes_reg;
    logic          stored_present_reg;

    // result register
    logic          out_valid_reg;
    logic          valid_res_reg;
    logic [4:0]    hour_reg;
    logic [5:0]    minute_reg;
    logic          changed_reg;

    logic          s1_go;
    logic          chg_next;

    tsp_step u_step (
        .cur       (state_reg),
        .char_code (char_reg),
        .last_char (last_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    // advance the held byte; a final byte needs room in the result register
    assign s1_go    = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || s1_go;

    assign chg_next = step_res.valid
        && (!stored_present_reg
            || (stored_hours_reg != step_res.hours)
            || (stored_minutes_reg != step_res.minutes));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= CLEAR_STATE;
            stored_hours_reg   <= 5'd0;
            stored_minutes_reg <= 6'd0;
            stored_present_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
            // replace the stored time only on a new valid time
            if (last_reg && chg_next)
            begin
                stored_hours_reg   <= step_res.hours;
                stored_minutes_reg <= step_res.minutes;
                stored_present_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && last_reg)
        begin
            valid_res_reg <= step_res.valid;
            hour_reg      <= step_res.hours;
            minute_reg    <= step_res.minutes;
            changed_reg   <= chg_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign hour_value   = hour_reg;
    assign minute_value = minute_reg;
    assign changed      = changed_reg;

    // an invalid result carries zero fields and no change
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (hour_value == 5'd0 && minute_value == 6'd0 && !changed))
        else $error("invalid result with nonzero fields");

    // a valid result stays in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (hour_value <= 5'd23 && minute_value <= 6'd59))
        else $error("result out of range");

    // a change reported matches the stored time
    a_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed) |->
            (stored_present_reg && stored_hours_reg == hour_value
             && stored_minutes_reg == minute_value))
        else $error("stored time does not match changed result");

    // per-payload state clears after a final byte
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && last_reg) |=> (state_reg.char_count == 4'd0 && !state_reg.failed))
        else $error("parse state not cleared after final byte");

endmodule

[sv/tsp_step.sv]
// Per-character parse step: next parse state and the result check on the final item.
// Depends on tsp_pkg.
module tsp_step (
    input  tsp_pkg::parse_state_t  cur,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    output tsp_pkg::parse_state_t  nxt,
    output tsp_pkg::parse_result_t res
);
    import tsp_pkg::*;

    parse_state_t upd;
    logic         digit;
    logic         colon;
    logic         ok;

    always_comb
    begin
        upd   = cur;
        digit = is_digit(char_code);
        colon = (char_code == COLON_CODE);

        // saturate the length count one past the limit
        if (cur.char_count <= 4'(MaxLen))
        begin
            upd.char_count = cur.char_count + 4'd1;
        end

        if (!cur.ended && !cur.failed)
        begin
            if (char_code == NUL_CODE)
            begin
                upd.ended = 1'b1;
            end
            else
            begin
                unique case (cur.phase)
                    PH_H1:
                    begin
                        if (digit)
                        begin
                            upd.hour_acc = add_digit(7'd0, char_code);
                            upd.phase    = PH_H2_OR_COLON;
                        end
                        else upd.failed = 1'b1;
                    end
                    PH_H2_OR_COLON:
                    begin
                        if (digit)
                        begin
                            upd.hour_acc = add_digit(cur.hour_acc, char_code);
                            upd.phase    = PH_COLON;
                        end
                        else if (colon) upd.phase = PH_M1;
                        else upd.failed = 1'b1;
                    end
                    PH_COLON:
                    begin
                        if (colon) upd.phase = PH_M1;
                        else upd.failed = 1'b1;
                    end
                    PH_M1:
                    begin
                        if (digit)
                        begin
                            upd.minute_acc = add_digit(7'd0, char_code);
                            upd.phase      = PH_M2;
                        end
                        else upd.failed = 1'b1;
                    end
                    PH_M2:
                    begin
                        if (digit)
                        begin
                            upd.minute_acc = add_digit(cur.minute_acc, char_code);
                            upd.phase      = PH_END_OR_COLON;
                        end
                        else upd.failed = 1'b1;
                    end
                    PH_END_OR_COLON:
                    begin
                        if (colon) upd.phase = PH_S1;
                        else upd.failed = 1'b1;
                    end
                    PH_S1:
                    begin
                        if (digit)
                        begin
                            upd.second_acc = add_digit(7'd0, char_code);
                            upd.phase      = PH_S2;
                        end
                        else upd.failed = 1'b1;
                    end
                    PH_S2:
                    begin
                        if (digit)
                        begin
                            upd.second_acc = add_digit(cur.second_acc, char_code);
                            upd.phase      = PH_END;
                        end
                        else upd.failed = 1'b1;
                    end
                    default:
                    begin
                        upd.failed = 1'b1;
                    end
                endcase
            end
        end

        ok = !upd.failed
            && (upd.phase == PH_END_OR_COLON || upd.phase == PH_END)
            && (upd.char_count >= 4'd1) && (upd.char_count <= 4'(MaxLen))
            && (upd.hour_acc <= 7'(HourMax))
            && (upd.minute_acc <= 7'(MinSecMax))
            && (upd.second_acc <= 7'(MinSecMax));

        res.valid   = ok;
        res.hours   = ok ? upd.hour_acc[4:0] : 5'd0;
        res.minutes = ok ? upd.minute_acc[5:0] : 6'd0;

        // the final item returns the per-payload state to its cleared value
        nxt = last_char ? CLEAR_STATE : upd;
    end

endmodule
